>>> design/length_prefixed_packet_ring_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed packet ring
// Short forms for a clocked implication, checked in the same cycle or in
// the next one, with reset masking the check.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_RING_TOP_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_RING_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPPR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/lppr_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet ring package
// Shared constants, command and status codes, sequencer states and the
// result word layout.
// ----------------------------------------------------------------------------
package lppr_pkg;

   localparam int LPPR_DEPTH = 64;   // default ring depth in entries
   localparam int BYTE_W     = 8;
   localparam int FREE_W     = 7;    // width of the reported free count

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_BUSY  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_DROP  = 2'd3
   } lppr_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PUSH,
      S_HDR,
      S_POP_HDR,
      S_POP_RD,
      S_POP_DATA,
      S_EMIT
   } lppr_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              valid;
      logic              last;
      lppr_status_type   status;
   } lppr_result_type;

endpackage

>>> design/lppr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is requested.
// ----------------------------------------------------------------------------
module lppr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/length_prefixed_packet_ring_top.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet ring
// Byte ring holding whole packets, each as a length header and its bytes.
// ----------------------------------------------------------------------------
// A push word adds one byte to the packet being assembled; the first byte
// reserves a header entry and the end-of-packet byte writes the length into
// it, committing the packet. A packet that needs more entries than are free
// (length plus header) is dropped whole with status 3, and the rest of it up
// to its end byte is dropped the same way. A pop word, when tx_busy is low
// and a packet is committed, returns the oldest packet as one response word
// per byte, tlast on the final one; otherwise one word with status busy (1)
// or empty (2). Every response carries the free entry count after the step.
// Flow: one word is taken at a time and req_tready is high only while the
// sequencer is idle. A push steps through execute, RAM write and response;
// an end-of-packet byte that commits adds a header step (the header write
// is a second RAM write), and a byte of a packet already being dropped
// skips the RAM write. A refused pop goes from execute to the response. A
// pop reads the header, then, as the RAM has a registered read, each byte
// takes an address step, a data step and a step to load the response
// register. Back-pressure on the response side holds the sequencer in the
// response step. All index arithmetic uses one shared wrap-around incrementer.
// ----------------------------------------------------------------------------
`include "length_prefixed_packet_ring_top_macros.svh"

module length_prefixed_packet_ring_top #(
   parameter int DEPTH = lppr_pkg::LPPR_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] tx_busy, rest zero
   input  logic        req_tlast,   // end_of_packet
   input  logic        req_tuser,   // [0] cmd (0 push, 1 pop)
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [14:8] free_space, [15] zero
   output logic        rsp_tlast,   // last_of_run
   output logic [2:0]  rsp_tuser    // [0] byte_valid, [2:1] status
);

   localparam int AW = $clog2(DEPTH);              // ring index width
   localparam int FW = $clog2(DEPTH + 1);          // free entry count width
   localparam int LW = ((FW > 8) ? FW : 8) + 1;    // header clamp compare width
   localparam int BW = lppr_pkg::BYTE_W;

   // sequencer and ring bookkeeping
   lppr_pkg::lppr_state_type state_ff, state_in;
   logic [AW-1:0] write_index_ff, write_index_in;
   logic [AW-1:0] read_index_ff,  read_index_in;
   logic [AW-1:0] header_slot_ff, header_slot_in;
   logic [AW-1:0] pending_ff,     pending_in;
   logic [FW-1:0] free_ff,        free_in;
   logic          drop_ff,        drop_in;
   logic [AW-1:0] pos_ff,         pos_in;
   logic [AW-1:0] remain_ff,      remain_in;

   // captured request word
   logic          cmd_ff,  cmd_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic          eop_ff,  eop_in;
   logic          busy_ff, busy_in;

   // staged result and response register
   lppr_pkg::lppr_result_type stg_ff, stg_in;
   lppr_pkg::lppr_result_type out_ff, out_in;
   logic [lppr_pkg::FREE_W-1:0] out_free_ff, out_free_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // RAM port
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [BW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [BW-1:0] ram_rd_data;

   // shared incrementer and decode
   logic [AW-1:0] inc_arg;
   logic [AW-1:0] inc_out;
   logic          ring_empty;
   logic          push_fail;
   logic [FW:0]   push_need;
   logic [FW-1:0] used;
   logic [FW-1:0] len_lim;
   logic [FW-1:0] len_clamp;
   logic          slot_free;
   logic          pop_go;

   lppr_ram #(
      .WIDTH (BW),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared wrap-around incrementer; the operand depends on the step.
   always_comb begin
      case (state_ff)
         lppr_pkg::S_POP_HDR: inc_arg = read_index_ff;
         lppr_pkg::S_POP_RD:  inc_arg = pos_ff;
         default:             inc_arg = write_index_ff;
      endcase
   end

   assign inc_out = (inc_arg == AW'(DEPTH - 1)) ? '0 : inc_arg + AW'(1);

   // Decode shared by the next-state and datapath blocks.
   always_comb begin
      ring_empty = (free_ff >= FW'(DEPTH));
      pop_go     = !busy_ff && !ring_empty;
      // packet needs its bytes so far, this byte and the header
      push_need  = (FW + 1)'(pending_ff) + (FW + 1)'(2);
      push_fail  = push_need > (FW + 1)'(free_ff);
      used       = FW'(DEPTH) - free_ff;
      len_lim    = used - FW'(1);
      // clamp a header that claims more than the committed entries hold
      len_clamp  = (LW'(ram_rd_data) > LW'(len_lim)) ? len_lim : FW'(ram_rd_data);
      slot_free  = !rsp_valid_ff || rsp_tready;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lppr_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = lppr_pkg::S_EXEC;
            end
         end
         lppr_pkg::S_EXEC: begin
            if (cmd_ff == lppr_pkg::CMD_POP) begin
               state_in = pop_go ? lppr_pkg::S_POP_HDR : lppr_pkg::S_EMIT;
            end else begin
               state_in = drop_ff ? lppr_pkg::S_EMIT : lppr_pkg::S_PUSH;
            end
         end
         lppr_pkg::S_PUSH: begin
            state_in = (!push_fail && eop_ff) ? lppr_pkg::S_HDR : lppr_pkg::S_EMIT;
         end
         lppr_pkg::S_HDR: begin
            state_in = lppr_pkg::S_EMIT;
         end
         lppr_pkg::S_POP_HDR: begin
            state_in = (len_clamp == '0) ? lppr_pkg::S_EMIT : lppr_pkg::S_POP_RD;
         end
         lppr_pkg::S_POP_RD: begin
            state_in = lppr_pkg::S_POP_DATA;
         end
         lppr_pkg::S_POP_DATA: begin
            state_in = lppr_pkg::S_EMIT;
         end
         lppr_pkg::S_EMIT: begin
            if (slot_free) begin
               state_in = stg_ff.last ? lppr_pkg::S_IDLE : lppr_pkg::S_POP_RD;
            end
         end
         default: begin
            state_in = lppr_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath, RAM control and response register.
   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      header_slot_in = header_slot_ff;
      pending_in     = pending_ff;
      free_in        = free_ff;
      drop_in        = drop_ff;
      pos_in         = pos_ff;
      remain_in      = remain_ff;
      cmd_in         = cmd_ff;
      byte_in        = byte_ff;
      eop_in         = eop_ff;
      busy_in        = busy_ff;
      stg_in         = stg_ff;
      out_in         = out_ff;
      out_free_in    = out_free_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = write_index_ff;
      ram_wr_data    = byte_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = read_index_ff;

      case (state_ff)
         lppr_pkg::S_IDLE: begin
            // capture the request word
            cmd_in  = req_tuser;
            byte_in = req_tdata[BW-1:0];
            eop_in  = req_tlast;
            busy_in = req_tdata[BW];
         end
         lppr_pkg::S_EXEC: begin
            stg_in.data  = '0;
            stg_in.valid = 1'b0;
            stg_in.last  = 1'b1;
            stg_in.status = lppr_pkg::STAT_OK;
            if (cmd_ff == lppr_pkg::CMD_POP) begin
               if (busy_ff) begin
                  stg_in.status = lppr_pkg::STAT_BUSY;
               end else if (ring_empty) begin
                  stg_in.status = lppr_pkg::STAT_EMPTY;
               end else begin
                  // fetch the oldest header
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = read_index_ff;
               end
            end else if (drop_ff) begin
               // discard up to and including the end byte
               stg_in.status = lppr_pkg::STAT_DROP;
               if (eop_ff) begin
                  drop_in = 1'b0;
               end
            end else if (pending_ff == '0) begin
               // reserve the header entry
               header_slot_in = write_index_ff;
               write_index_in = inc_out;
            end
         end
         lppr_pkg::S_PUSH: begin
            if (push_fail) begin
               // abandon the packet, rewind to its header
               write_index_in = header_slot_ff;
               pending_in     = '0;
               drop_in        = !eop_ff;
               stg_in.status  = lppr_pkg::STAT_DROP;
            end else begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = write_index_ff;
               ram_wr_data    = byte_ff;
               write_index_in = inc_out;
               pending_in     = pending_ff + AW'(1);
            end
         end
         lppr_pkg::S_HDR: begin
            // commit: write the length and claim its entries
            ram_wr_en   = 1'b1;
            ram_wr_addr = header_slot_ff;
            ram_wr_data = BW'(pending_ff);
            free_in     = free_ff - (FW'(pending_ff) + FW'(1));
            pending_in  = '0;
         end
         lppr_pkg::S_POP_HDR: begin
            free_in   = free_ff + len_clamp + FW'(1);
            remain_in = AW'(len_clamp);
            pos_in    = inc_out;
            if (len_clamp == '0) begin
               read_index_in = inc_out;
            end
         end
         lppr_pkg::S_POP_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_ff;
            pos_in      = inc_out;
            remain_in   = remain_ff - AW'(1);
            if (remain_ff == AW'(1)) begin
               // past the final byte: next header
               read_index_in = inc_out;
            end
         end
         lppr_pkg::S_POP_DATA: begin
            stg_in.data   = ram_rd_data;
            stg_in.valid  = 1'b1;
            stg_in.last   = (remain_ff == '0);
            stg_in.status = lppr_pkg::STAT_OK;
         end
         lppr_pkg::S_EMIT: begin
            if (slot_free) begin
               out_in       = stg_ff;
               out_free_in  = lppr_pkg::FREE_W'(free_ff);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lppr_pkg::S_IDLE;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         header_slot_ff <= '0;
         pending_ff     <= '0;
         free_ff        <= FW'(DEPTH);
         drop_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         header_slot_ff <= header_slot_in;
         pending_ff     <= pending_in;
         free_ff        <= free_in;
         drop_ff        <= drop_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      remain_ff   <= remain_in;
      cmd_ff      <= cmd_in;
      byte_ff     <= byte_in;
      eop_ff      <= eop_in;
      busy_ff     <= busy_in;
      stg_ff      <= stg_in;
      out_ff      <= out_in;
      out_free_ff <= out_free_in;
   end

   // Take a word only while idle.
   assign req_tready = (state_ff == lppr_pkg::S_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_free_ff, out_ff.data};
   assign rsp_tlast  = out_ff.last;
   assign rsp_tuser  = {out_ff.status, out_ff.valid};

   // An accepted word always starts execution next cycle.
   `LPPR_ASSERT_NEXT(a_accept_exec, clock, reset, req_tvalid && req_tready,
      state_ff == lppr_pkg::S_EXEC, "accepted word did not start execution")

   // While dropping, no partial packet is held.
   `LPPR_ASSERT_NOW(a_drop_no_pending, clock, reset, drop_ff,
      pending_ff == '0, "drop active with bytes pending")

   // A packet under assembly always fits with its header.
   `LPPR_ASSERT_NOW(a_pending_fits, clock, reset, pending_ff != '0,
      (FW + 1)'(pending_ff) + (FW + 1)'(1) <= (FW + 1)'(free_ff),
      "pending packet exceeds free entries")

   // A byte fetch only happens with bytes left to send.
   `LPPR_ASSERT_NOW(a_pop_remain, clock, reset, state_ff == lppr_pkg::S_POP_RD,
      remain_ff != '0, "byte fetch with nothing left")

endmodule

>>> bench/length_prefixed_packet_ring_top_tb.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet ring testbench
// Pushes whole and cut-short packets, pops them back and refuses pops, then
// checks every response word against a behavioral copy of the ring that is
// kept in step with each accepted request word.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = lppr_pkg::LPPR_DEPTH;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int HOLD_LEN  = 300;       // cycles of the long response hold
   localparam int TAIL_WAIT = 40;        // quiet cycles after the last word

   // One predicted response word, split into its fields.
   typedef struct {
      logic [lppr_pkg::BYTE_W-1:0] data;
      logic                        valid;
      logic                        last;
      lppr_pkg::lppr_status_type   status;
      logic [lppr_pkg::FREE_W-1:0] free;
   } ring_word_type;

   // DUT ports; every input starts at a known value.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] data_byte, [8] tx_busy, rest zero
   logic        req_tlast  = 1'b0; // end_of_packet
   logic        req_tuser  = 1'b0; // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] out_byte, [14:8] free_space, [15] zero
   logic        rsp_tlast;         // last_of_run
   logic [2:0]  rsp_tuser;         // [0] byte_valid, [2:1] status

   // Shadow ring state, advanced once per accepted request word.
   logic [lppr_pkg::BYTE_W-1:0] ring_bytes [DEPTH];
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  hdr_slot;
   int                pend_len;
   int                free_cnt;
   bit                dropping;

   // Response words still owed by the block, oldest first.
   ring_word_type ring_out_q [$];
   ring_word_type head_word;

   // Idle / stall knobs, in percent per cycle.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        rsp_hold = 1'b0;
   event        hold_rsp_go;

   // Bookkeeping for the summary.
   int unsigned fault_count   = 0;
   int unsigned words_sent    = 0;
   int unsigned words_checked = 0;
   int unsigned pkts_popped   = 0;
   int unsigned drop_reports  = 0;
   int unsigned busy_refusals = 0;
   int unsigned empty_refusals = 0;

   length_prefixed_packet_ring_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Ring behavior: apply one request word and queue the words it causes.
   // ------------------------------------------------------------------------
   function automatic void ring_reset_state();
      foreach (ring_bytes[i]) ring_bytes[i] = '0;
      wr_idx   = '0;
      rd_idx   = '0;
      hdr_slot = '0;
      pend_len = 0;
      free_cnt = DEPTH;
      dropping = 1'b0;
   endfunction

   function automatic void advance_ring(logic cmd,
                                        logic [lppr_pkg::BYTE_W-1:0] data_byte,
                                        logic eop, logic tx_busy);
      ring_word_type    w;
      int               count;
      int               used;
      int               len;
      logic [IDX_W-1:0] pos;

      w.data   = '0;
      w.valid  = 1'b0;
      w.last   = 1'b1;
      w.status = lppr_pkg::STAT_OK;

      if (cmd == lppr_pkg::CMD_PUSH) begin
         if (dropping) begin
            // discard the tail of an overflowed packet up to its end byte
            if (eop) dropping = 1'b0;
            w.status = lppr_pkg::STAT_DROP;
         end else begin
            if (pend_len == 0) begin
               // first byte: reserve the header entry
               hdr_slot = wr_idx;
               wr_idx   = IDX_W'((hdr_slot + 1) % DEPTH);
            end
            count = pend_len + 1;
            if (count + 1 > free_cnt) begin
               // abandon the whole packet, rewind to its header
               wr_idx   = hdr_slot;
               pend_len = 0;
               dropping = !eop;
               w.status = lppr_pkg::STAT_DROP;
            end else begin
               ring_bytes[wr_idx] = data_byte;
               wr_idx   = IDX_W'((wr_idx + 1) % DEPTH);
               pend_len = count;
               if (eop) begin
                  // commit: write the length into the header entry
                  ring_bytes[hdr_slot] = lppr_pkg::BYTE_W'(count);
                  free_cnt -= count + 1;
                  pend_len  = 0;
               end
            end
         end
         if (w.status == lppr_pkg::STAT_DROP) drop_reports++;
         w.free = lppr_pkg::FREE_W'(free_cnt);
         ring_out_q.push_back(w);
      end else if (tx_busy) begin
         // busy wins over empty
         w.status = lppr_pkg::STAT_BUSY;
         w.free   = lppr_pkg::FREE_W'(free_cnt);
         busy_refusals++;
         ring_out_q.push_back(w);
      end else if (free_cnt >= DEPTH) begin
         w.status = lppr_pkg::STAT_EMPTY;
         w.free   = lppr_pkg::FREE_W'(free_cnt);
         empty_refusals++;
         ring_out_q.push_back(w);
      end else begin
         used = DEPTH - free_cnt;
         len  = ring_bytes[rd_idx];
         if (len > used - 1) len = used - 1;   // clamp a bad header
         pos      = IDX_W'((rd_idx + 1) % DEPTH);
         rd_idx   = IDX_W'((rd_idx + len + 1) % DEPTH);
         free_cnt += len + 1;
         if (len == 0) begin
            w.free = lppr_pkg::FREE_W'(free_cnt);
            ring_out_q.push_back(w);
         end else begin
            pkts_popped++;
            for (int i = 0; i < len; i++) begin
               w.data  = ring_bytes[pos];
               w.valid = 1'b1;
               w.last  = (i == len - 1);
               w.free  = lppr_pkg::FREE_W'(free_cnt);
               ring_out_q.push_back(w);
               pos = IDX_W'((pos + 1) % DEPTH);
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Offer one word; return at the edge that accepts it, valid left high.
   task automatic send_word(logic cmd, logic [lppr_pkg::BYTE_W-1:0] data_byte,
                            logic eop, logic tx_busy);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= eop;
      req_tdata  <= {7'b0, tx_busy, data_byte};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      advance_ring(cmd, data_byte, eop, tx_busy);
   endtask

   task automatic pop_word(logic tx_busy);
      // data and end mark are don't-care on a pop: fill them with noise
      send_word(lppr_pkg::CMD_POP, lppr_pkg::BYTE_W'($urandom), 1'($urandom), tx_busy);
   endtask

   // Push an len-byte packet of random bytes; sometimes pop in the middle.
   task automatic push_packet(int len, int unsigned mid_pop_pct);
      int cut;

      cut = ($urandom_range(99) < mid_pop_pct && len > 1) ? $urandom_range(len - 1, 1)
                                                          : 0;
      for (int i = 0; i < len; i++) begin
         if (cut != 0 && i == cut) pop_word($urandom_range(99) < 15);
         send_word(lppr_pkg::CMD_PUSH, lppr_pkg::BYTE_W'($urandom), i == len - 1,
                   1'($urandom));
      end
   endtask

   // Mostly short packets, some medium, a few long ones up to the full ring.
   function automatic int pick_len();
      int r;

      r = $urandom_range(99);
      if (r < 70) return $urandom_range(6, 1);
      if (r < 92) return $urandom_range(20, 7);
      return $urandom_range(DEPTH - 1, 21);
   endfunction

   task automatic random_traffic(int unsigned n_words);
      int unsigned start;
      int unsigned pick;

      start = words_sent;
      while (words_sent - start < n_words) begin
         pick = $urandom_range(99);
         if (pick < 58) push_packet(pick_len(), 15);
         else pop_word($urandom_range(99) < 15);
      end
   endtask

   // Drop valid, let every owed word drain, then let the sequencer settle.
   task automatic wait_ring_idle();
      req_tvalid <= 1'b0;
      while (ring_out_q.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   // Own the long hold: count it out here, independent of the sender.
   initial begin
      forever begin
         @(hold_rsp_go);
         rsp_hold <= 1'b1;
         repeat (HOLD_LEN) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (rsp_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         fault_count++;
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name,
                  want, got);
      end
   endtask

   // Compare each accepted response word with the oldest owed word.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ring_out_q.size() == 0) begin
            fault_count++;
            $display("%0t ns: unexpected response word, expected none, got %h/%b/%b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            head_word = ring_out_q.pop_front();
            words_checked++;
            check_field("out_byte",    head_word.data,   rsp_tdata[7:0]);
            check_field("free_space",  head_word.free,   rsp_tdata[14:8]);
            check_field("tdata pad",   0,                rsp_tdata[15]);
            check_field("last_of_run", head_word.last,   rsp_tlast);
            check_field("byte_valid",  head_word.valid,  rsp_tuser[0]);
            check_field("status",      head_word.status, rsp_tuser[2:1]);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Pop an empty ring, idle and busy (busy must win).
   task automatic test_empty_ring();
      pop_word(1'b0);
      pop_word(1'b1);
      wait_ring_idle();
   endtask

   // Extreme bytes, a busy refusal with data held, and a pop that lands while
   // a packet is half assembled: only committed packets may come out.
   task automatic test_packet_order();
      send_word(lppr_pkg::CMD_PUSH, 8'h00, 1'b1, 1'b0);
      send_word(lppr_pkg::CMD_PUSH, 8'hFF, 1'b0, 1'b1);
      send_word(lppr_pkg::CMD_PUSH, 8'hA5, 1'b0, 1'b0);
      send_word(lppr_pkg::CMD_PUSH, 8'h5A, 1'b1, 1'b1);
      pop_word(1'b1);
      send_word(lppr_pkg::CMD_PUSH, 8'h12, 1'b0, 1'b0);
      send_word(lppr_pkg::CMD_POP,  8'hFF, 1'b1, 1'b0);
      send_word(lppr_pkg::CMD_PUSH, 8'h34, 1'b1, 1'b0);
      send_word(lppr_pkg::CMD_POP,  8'h00, 1'b0, 1'b0);
      pop_word(1'b0);
      pop_word(1'b0);
      wait_ring_idle();
   endtask

   // Fill the ring with one maximum packet, then overflow with an end byte
   // (no tail to drop) and with a packet whose tail must be dropped.
   task automatic test_full_ring_overflow();
      push_packet(DEPTH - 1, 0);
      send_word(lppr_pkg::CMD_PUSH, 8'hFF, 1'b1, 1'b0);
      send_word(lppr_pkg::CMD_PUSH, 8'h00, 1'b0, 1'b1);
      send_word(lppr_pkg::CMD_PUSH, 8'h81, 1'b0, 1'b0);
      send_word(lppr_pkg::CMD_PUSH, 8'h7E, 1'b1, 1'b0);
      pop_word(1'b0);
      wait_ring_idle();
   endtask

   // Random traffic under each idle / stall mix.
   task automatic test_idle_mix();
      int unsigned phase_idle  [4] = '{0, 52, 0, 11};
      int unsigned phase_stall [4] = '{0, 0, 52, 11};

      foreach (phase_idle[p]) begin
         req_idle_pct  = phase_idle[p];
         rsp_stall_pct = phase_stall[p];
         random_traffic(40);
         wait_ring_idle();
      end
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   // Hold the response side for a long stretch while words keep coming, so
   // the block backs up and drops req_tready.
   task automatic test_response_hold();
      -> hold_rsp_go;
      random_traffic(25);
      wait_ring_idle();
   endtask

   initial begin
      ring_reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_ring();
      test_packet_order();
      test_full_ring_overflow();
      test_idle_mix();
      test_response_hold();

      $display("Ran %0d request words: %0d packets popped, %0d drop reports,",
               words_sent, pkts_popped, drop_reports);
      $display("%0d busy and %0d empty refusals; %0d response words checked.",
               busy_refusals, empty_refusals, words_checked);
      if (fault_count == 0 && ring_out_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         if (ring_out_q.size() != 0)
            $display("%0t ns: %0d response words never arrived", $time,
                     ring_out_q.size());
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/lppr_pkg.sv
design/lppr_ram.sv
design/length_prefixed_packet_ring_top.sv
bench/length_prefixed_packet_ring_top_tb.sv
